/* rtl/macd_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the MACD indicator stream: widths, default periods,
// averaging commands and the control bundle for the bit-serial average units.
// No dependencies.
package macd_pkg;

    localparam int unsigned FAST_PERIOD_DEF   = 12;
    localparam int unsigned SLOW_PERIOD_DEF   = 26;
    localparam int unsigned SIGNAL_PERIOD_DEF = 9;

    // Price and result fields are Q16.16 / Q15.16 words.
    localparam int unsigned PRICE_WIDTH = 32;
    // Window sums of up to 64 prices and all averaging numerators fit here.
    localparam int unsigned AVG_WIDTH   = 40;
    // A difference of two 32-bit values, one guard bit for saturation.
    localparam int unsigned DIFF_WIDTH  = PRICE_WIDTH + 1;

    localparam logic [PRICE_WIDTH-1:0] SAT_MAX = {1'b0, {(PRICE_WIDTH-1){1'b1}}};
    localparam logic [PRICE_WIDTH-1:0] SAT_MIN = {1'b1, {(PRICE_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        AVG_ACCUM = 2'b00,  // add the sample to the window sum
        AVG_SEED  = 2'b01,  // close the window: (sum + x) / N
        AVG_EMA   = 2'b10   // (2x + (N-1)avg) / (N+1)
    } avg_op_t;

    typedef struct packed {
        logic    start;
        logic    clr;
        avg_op_t op;
    } avg_ctrl_t;

endpackage

/* rtl/macd_serial_avg.sv */
`timescale 1ns / 1ps
// Bit-serial averaging unit: keeps one 40-bit accumulator and applies one
// averaging command per start. Depends on macd_pkg.
module macd_serial_avg
    import macd_pkg::*;
#(
    parameter int unsigned Period = FAST_PERIOD_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  avg_ctrl_t            ctrl,
    input  logic [AVG_WIDTH-1:0] x_in,
    output logic                 busy,
    output logic [AVG_WIDTH-1:0] acc
);

    localparam int unsigned CoefWidth = $clog2(Period + 2);
    localparam int unsigned SumWidth  = $clog2(2 * (CoefWidth + 2) + 1);
    localparam int unsigned CntWidth  = $clog2(AVG_WIDTH);
    localparam logic [CntWidth-1:0]  LastBit = CntWidth'(AVG_WIDTH - 1);
    localparam logic [CoefWidth-1:0] EmaMul  = CoefWidth'(Period - 1);
    localparam logic [CoefWidth-1:0] SeedDiv = CoefWidth'(Period);
    localparam logic [CoefWidth-1:0] EmaDiv  = CoefWidth'(Period + 1);
    localparam logic [CoefWidth-1:0] OneMul  = CoefWidth'(1);

    typedef enum logic [4:0] {
        AVG_IDLE = 5'b00001,
        AVG_NUM  = 5'b00010,
        AVG_NEG1 = 5'b00100,
        AVG_DIV  = 5'b01000,
        AVG_NEG2 = 5'b10000
    } avg_state_t;

    avg_state_t             state_reg, state_next;
    logic [AVG_WIDTH-1:0]   work_reg, work_next;
    logic [AVG_WIDTH-1:0]   xsh_reg, xsh_next;
    logic [CoefWidth-2:0]   acc_win_reg, acc_win_next;
    logic                   x_prev_reg, x_prev_next;
    logic [CoefWidth-1:0]   mul_reg, mul_next;
    logic [1:0]             xmul_reg, xmul_next;
    logic [CoefWidth-1:0]   div_reg, div_next;
    logic                   do_div_reg, do_div_next;
    logic [SumWidth-2:0]    carry_reg, carry_next;
    logic [CoefWidth-1:0]   rem_reg, rem_next;
    logic                   sign_reg, sign_next;
    logic                   seen_reg, seen_next;
    logic [CntWidth-1:0]    cnt_reg, cnt_next;

    logic [CoefWidth-1:0]   accw;
    logic [1:0]             xw;
    logic [SumWidth-1:0]    num_sum;
    logic [CoefWidth:0]     trial;
    logic                   trial_ge;
    logic                   neg_bit;
    logic                   last_bit;

    assign busy = (state_reg != AVG_IDLE);
    assign acc  = work_reg;

    // Bit j of the numerator: weighted taps of the accumulator and sample streams.
    always_comb begin
        accw    = {acc_win_reg, work_reg[0]};
        xw      = {x_prev_reg, xsh_reg[0]};
        num_sum = SumWidth'(carry_reg);
        for (int k = 0; k < CoefWidth; k++) begin
            num_sum = num_sum + SumWidth'(mul_reg[k] & accw[k]);
        end
        for (int k = 0; k < 2; k++) begin
            num_sum = num_sum + SumWidth'(xmul_reg[k] & xw[k]);
        end
        trial    = {rem_reg, work_reg[AVG_WIDTH-1]};
        trial_ge = (trial >= {1'b0, div_reg});
        neg_bit  = work_reg[0] ^ seen_reg;
        last_bit = (cnt_reg == LastBit);
    end

    always_comb begin
        state_next   = state_reg;
        work_next    = work_reg;
        xsh_next     = xsh_reg;
        acc_win_next = acc_win_reg;
        x_prev_next  = x_prev_reg;
        mul_next     = mul_reg;
        xmul_next    = xmul_reg;
        div_next     = div_reg;
        do_div_next  = do_div_reg;
        carry_next   = carry_reg;
        rem_next     = rem_reg;
        sign_next    = sign_reg;
        seen_next    = seen_reg;
        // Every pass is one full word long; restart the bit count for the next pass.
        cnt_next     = last_bit ? '0 : cnt_reg + CntWidth'(1);

        unique case (state_reg)
            AVG_IDLE: begin
                cnt_next = '0;
                if (ctrl.start) begin
                    state_next   = AVG_NUM;
                    xsh_next     = x_in;
                    acc_win_next = '0;
                    x_prev_next  = 1'b0;
                    carry_next   = '0;
                    rem_next     = '0;
                    seen_next    = 1'b0;
                    unique case (ctrl.op)
                        AVG_ACCUM: begin
                            mul_next    = OneMul;
                            xmul_next   = 2'd1;
                            div_next    = SeedDiv;
                            do_div_next = 1'b0;
                        end
                        AVG_SEED: begin
                            mul_next    = OneMul;
                            xmul_next   = 2'd1;
                            div_next    = SeedDiv;
                            do_div_next = 1'b1;
                        end
                        AVG_EMA: begin
                            mul_next    = EmaMul;
                            xmul_next   = 2'd2;
                            div_next    = EmaDiv;
                            do_div_next = 1'b1;
                        end
                        default: begin
                            mul_next    = OneMul;
                            xmul_next   = 2'd1;
                            div_next    = SeedDiv;
                            do_div_next = 1'b0;
                        end
                    endcase
                end else if (ctrl.clr) begin
                    work_next = '0;
                end
            end
            AVG_NUM: begin
                // Rotate right: accumulator bit leaves, numerator bit enters on top.
                work_next    = {num_sum[0], work_reg[AVG_WIDTH-1:1]};
                xsh_next     = {1'b0, xsh_reg[AVG_WIDTH-1:1]};
                acc_win_next = accw[CoefWidth-2:0];
                x_prev_next  = xsh_reg[0];
                carry_next   = num_sum[SumWidth-1:1];
                if (last_bit) begin
                    sign_next = num_sum[0];
                    if (!do_div_reg) begin
                        state_next = AVG_IDLE;
                    end else if (num_sum[0]) begin
                        state_next = AVG_NEG1;
                    end else begin
                        state_next = AVG_DIV;
                    end
                end
            end
            AVG_NEG1: begin
                work_next = {neg_bit, work_reg[AVG_WIDTH-1:1]};
                seen_next = seen_reg | work_reg[0];
                if (last_bit) begin
                    state_next = AVG_DIV;
                end
            end
            AVG_DIV: begin
                // Long division by a small constant, one quotient bit per cycle.
                work_next = {work_reg[AVG_WIDTH-2:0], trial_ge};
                rem_next  = trial_ge ? CoefWidth'(trial - {1'b0, div_reg})
                                     : trial[CoefWidth-1:0];
                seen_next = 1'b0;
                if (last_bit) begin
                    state_next = sign_reg ? AVG_NEG2 : AVG_IDLE;
                end
            end
            AVG_NEG2: begin
                work_next = {neg_bit, work_reg[AVG_WIDTH-1:1]};
                seen_next = seen_reg | work_reg[0];
                if (last_bit) begin
                    state_next = AVG_IDLE;
                end
            end
            default: begin
                state_next = AVG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AVG_IDLE;
            work_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            work_reg  <= work_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        xsh_reg     <= xsh_next;
        acc_win_reg <= acc_win_next;
        x_prev_reg  <= x_prev_next;
        mul_reg     <= mul_next;
        xmul_reg    <= xmul_next;
        div_reg     <= div_next;
        do_div_reg  <= do_div_next;
        carry_reg   <= carry_next;
        rem_reg     <= rem_next;
        sign_reg    <= sign_next;
        seen_reg    <= seen_next;
    end

endmodule

/* rtl/macd_serial_sub.sv */
`timescale 1ns / 1ps
// Bit-serial subtractor with saturation to a signed 32-bit word, shared for
// the MACD line and the histogram. Depends on macd_pkg.
module macd_serial_sub
    import macd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [DIFF_WIDTH-1:0]  a_in,
    input  logic [DIFF_WIDTH-1:0]  b_in,
    output logic                   busy,
    output logic [PRICE_WIDTH-1:0] result
);

    localparam int unsigned CntWidth = $clog2(DIFF_WIDTH);
    localparam logic [CntWidth-1:0] LastBit = CntWidth'(DIFF_WIDTH - 1);

    logic                  busy_reg, busy_next;
    logic [CntWidth-1:0]   cnt_reg, cnt_next;
    logic [DIFF_WIDTH-1:0] a_reg, a_next;
    logic [DIFF_WIDTH-1:0] b_reg, b_next;
    logic [DIFF_WIDTH-1:0] r_reg, r_next;
    logic                  carry_reg, carry_next;
    logic [1:0]            bit_sum;

    assign busy = busy_reg;

    always_comb begin
        bit_sum    = {1'b0, a_reg[0]} + {1'b0, ~b_reg[0]} + {1'b0, carry_reg};
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        carry_next = carry_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next  = 1'b1;
                cnt_next   = '0;
                a_next     = a_in;
                b_next     = b_in;
                carry_next = 1'b1;
            end
        end else begin
            a_next     = {1'b0, a_reg[DIFF_WIDTH-1:1]};
            b_next     = {1'b0, b_reg[DIFF_WIDTH-1:1]};
            r_next     = {bit_sum[0], r_reg[DIFF_WIDTH-1:1]};
            carry_next = bit_sum[1];
            cnt_next   = cnt_reg + CntWidth'(1);
            if (cnt_reg == LastBit) begin
                busy_next = 1'b0;
            end
        end
    end

    // Clamp when the guard bit disagrees with the sign of the 32-bit word.
    always_comb begin
        if (r_reg[DIFF_WIDTH-1] != r_reg[PRICE_WIDTH-1]) begin
            result = r_reg[DIFF_WIDTH-1] ? SAT_MIN : SAT_MAX;
        end else begin
            result = r_reg[PRICE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        r_reg     <= r_next;
        carry_reg <= carry_next;
    end

endmodule

/* rtl/macd_indicator_stream.sv */
`timescale 1ns / 1ps
// MACD indicator stream, top level. Uses macd_pkg, macd_serial_avg and
// macd_serial_sub.
//
// One closing price (unsigned Q16.16) goes in per item; from the sample that
// completes the signal window on (index SlowPeriod+SignalPeriod-2 of a series,
// the 34th sample with 12/26/9) one result item comes out per price: the price,
// the fast and slow averages, the MACD line, the signal line and the histogram.
// Earlier samples of a series only feed the averages and produce nothing.
// Raising start_of_series with a price clears all averages and the sample
// count first, so that price opens a new series. Each average starts as the
// plain mean of its first window and then follows (2x + (N-1)avg) / (N+1);
// divisions round toward zero, MACD and histogram saturate to 32 bits.
// The datapath is bit-serial: every addition, constant multiplication and
// division walks through 40-bit shift registers one bit per cycle. Fast and
// slow averages run side by side, then MACD, signal and histogram follow in
// turn. While a window fills its average only adds; once it has closed, the
// average also runs a division pass, and a negative signal numerator adds
// two negation passes. The signal average runs only once the slow window has
// closed, the histogram only for items that give a result. One item is worked
// on at a time; a finished result waits in the output register, and the next
// item is taken while it waits.
module macd_indicator_stream
    import macd_pkg::*;
#(
    parameter int unsigned FastPeriod   = FAST_PERIOD_DEF,
    parameter int unsigned SlowPeriod   = SLOW_PERIOD_DEF,
    parameter int unsigned SignalPeriod = SIGNAL_PERIOD_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [PRICE_WIDTH-1:0]        s_close_price,
    input  logic                          s_start_of_series,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [PRICE_WIDTH-1:0]        m_price_echo,
    output logic [PRICE_WIDTH-1:0]        m_fast_average,
    output logic [PRICE_WIDTH-1:0]        m_slow_average,
    output logic signed [PRICE_WIDTH-1:0] m_macd_line,
    output logic signed [PRICE_WIDTH-1:0] m_signal_line,
    output logic signed [PRICE_WIDTH-1:0] m_histogram
);

    localparam int unsigned Warmup     = SlowPeriod + SignalPeriod - 2;
    localparam int unsigned CapA       = (FastPeriod > SlowPeriod) ? FastPeriod : SlowPeriod;
    localparam int unsigned CountCap   = (CapA > Warmup + 1) ? CapA : Warmup + 1;
    localparam int unsigned CountWidth = $clog2(CountCap + 1);
    localparam int unsigned CmpWidth   = CountWidth + 1;
    localparam int unsigned ExtWidth   = AVG_WIDTH - PRICE_WIDTH;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_AVG  = 6'b000010,
        ST_MACD = 6'b000100,
        ST_SIG  = 6'b001000,
        ST_HIST = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    go_reg, go_next;
    logic [CountWidth-1:0]   count_reg, count_next;
    logic [PRICE_WIDTH-1:0]  price_reg, price_next;
    logic [PRICE_WIDTH-1:0]  macd_reg, macd_next;

    logic                    m_valid_reg, m_valid_next;
    logic [PRICE_WIDTH-1:0]  m_price_reg, m_price_next;
    logic [PRICE_WIDTH-1:0]  m_fast_reg, m_fast_next;
    logic [PRICE_WIDTH-1:0]  m_slow_reg, m_slow_next;
    logic [PRICE_WIDTH-1:0]  m_macd_reg, m_macd_next;
    logic [PRICE_WIDTH-1:0]  m_sig_reg, m_sig_next;
    logic [PRICE_WIDTH-1:0]  m_hist_reg, m_hist_next;

    logic                    in_fire;
    logic [CmpWidth-1:0]     idx;
    logic [CmpWidth-1:0]     idx_inc;
    logic                    fast_seeded, fast_seed_now;
    logic                    slow_seeded, slow_seed_now;
    logic                    sig_active, sig_accum, sig_seed_now;
    logic                    emit;

    avg_ctrl_t               fast_ctrl, slow_ctrl, sig_ctrl;
    logic                    fast_busy, slow_busy, sig_busy;
    logic [AVG_WIDTH-1:0]    fast_acc, slow_acc, sig_acc;
    logic [AVG_WIDTH-1:0]    price_ext, macd_ext;
    logic [PRICE_WIDTH-1:0]  fast_val, slow_val, sig_val;

    logic                    sub_start, sub_busy;
    logic [DIFF_WIDTH-1:0]   sub_a, sub_b;
    logic [PRICE_WIDTH-1:0]  sub_result;

    assign s_ready        = (state_reg == ST_IDLE);
    assign in_fire        = s_valid && s_ready;

    assign m_valid        = m_valid_reg;
    assign m_price_echo   = m_price_reg;
    assign m_fast_average = m_fast_reg;
    assign m_slow_average = m_slow_reg;
    assign m_macd_line    = m_macd_reg;
    assign m_signal_line  = m_sig_reg;
    assign m_histogram    = m_hist_reg;

    // Where this sample sits in its series decides each average's command.
    assign idx           = {1'b0, count_reg};
    assign idx_inc       = idx + CmpWidth'(1);
    assign fast_seeded   = (idx_inc >= CmpWidth'(FastPeriod));
    assign fast_seed_now = (idx_inc == CmpWidth'(FastPeriod));
    assign slow_seeded   = (idx_inc >= CmpWidth'(SlowPeriod));
    assign slow_seed_now = (idx_inc == CmpWidth'(SlowPeriod));
    assign sig_active    = (idx_inc >= CmpWidth'(SlowPeriod));
    assign sig_accum     = (idx < CmpWidth'(Warmup));
    assign sig_seed_now  = (idx == CmpWidth'(Warmup));
    assign emit          = (idx >= CmpWidth'(Warmup));

    // An average that has not closed its first window counts as zero.
    assign fast_val = fast_seeded ? fast_acc[PRICE_WIDTH-1:0] : '0;
    assign slow_val = slow_seeded ? slow_acc[PRICE_WIDTH-1:0] : '0;
    assign sig_val  = emit ? sig_acc[PRICE_WIDTH-1:0] : '0;

    assign price_ext = {{ExtWidth{1'b0}}, price_reg};
    assign macd_ext  = {{ExtWidth{macd_reg[PRICE_WIDTH-1]}}, macd_reg};

    always_comb begin
        fast_ctrl.start = go_reg && (state_reg == ST_AVG);
        fast_ctrl.clr   = in_fire && s_start_of_series;
        fast_ctrl.op    = !fast_seeded ? AVG_ACCUM : (fast_seed_now ? AVG_SEED : AVG_EMA);

        slow_ctrl.start = go_reg && (state_reg == ST_AVG);
        slow_ctrl.clr   = in_fire && s_start_of_series;
        slow_ctrl.op    = !slow_seeded ? AVG_ACCUM : (slow_seed_now ? AVG_SEED : AVG_EMA);

        sig_ctrl.start  = go_reg && (state_reg == ST_SIG);
        sig_ctrl.clr    = in_fire && s_start_of_series;
        sig_ctrl.op     = sig_accum ? AVG_ACCUM : (sig_seed_now ? AVG_SEED : AVG_EMA);
    end

    // One subtractor serves fast - slow first and MACD - signal afterwards.
    always_comb begin
        sub_start = go_reg && ((state_reg == ST_MACD) || (state_reg == ST_HIST));
        if (state_reg == ST_MACD) begin
            sub_a = {1'b0, fast_val};
            sub_b = {1'b0, slow_val};
        end else begin
            sub_a = {macd_reg[PRICE_WIDTH-1], macd_reg};
            sub_b = {sig_val[PRICE_WIDTH-1], sig_val};
        end
    end

    always_comb begin
        state_next   = state_reg;
        go_next      = 1'b0;
        count_next   = count_reg;
        price_next   = price_reg;
        macd_next    = macd_reg;
        m_valid_next = m_valid_reg;
        m_price_next = m_price_reg;
        m_fast_next  = m_fast_reg;
        m_slow_next  = m_slow_reg;
        m_macd_next  = m_macd_reg;
        m_sig_next   = m_sig_reg;
        m_hist_next  = m_hist_reg;

        // Drop the held result once it is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    price_next = s_close_price;
                    if (s_start_of_series) begin
                        count_next = '0;
                    end
                    state_next = ST_AVG;
                    go_next    = 1'b1;
                end
            end
            ST_AVG: begin
                if (!go_reg && !fast_busy && !slow_busy) begin
                    state_next = ST_MACD;
                    go_next    = 1'b1;
                end
            end
            ST_MACD: begin
                if (!go_reg && !sub_busy) begin
                    macd_next = sub_result;
                    if (sig_active) begin
                        state_next = ST_SIG;
                        go_next    = 1'b1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SIG: begin
                if (!go_reg && !sig_busy) begin
                    if (emit) begin
                        state_next = ST_HIST;
                        go_next    = 1'b1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HIST: begin
                if (!go_reg && !sub_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold here until the output register is free for this result.
                if (!emit || !m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                    if (idx < CmpWidth'(CountCap)) begin
                        count_next = count_reg + CountWidth'(1);
                    end
                    if (emit) begin
                        m_valid_next = 1'b1;
                        m_price_next = price_reg;
                        m_fast_next  = fast_val;
                        m_slow_next  = slow_val;
                        m_macd_next  = macd_reg;
                        m_sig_next   = sig_val;
                        m_hist_next  = sub_result;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            go_reg      <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            go_reg      <= go_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        price_reg   <= price_next;
        macd_reg    <= macd_next;
        m_price_reg <= m_price_next;
        m_fast_reg  <= m_fast_next;
        m_slow_reg  <= m_slow_next;
        m_macd_reg  <= m_macd_next;
        m_sig_reg   <= m_sig_next;
        m_hist_reg  <= m_hist_next;
    end

    macd_serial_avg #(
        .Period (FastPeriod)
    ) u_fast_avg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fast_ctrl),
        .x_in    (price_ext),
        .busy    (fast_busy),
        .acc     (fast_acc)
    );

    macd_serial_avg #(
        .Period (SlowPeriod)
    ) u_slow_avg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (slow_ctrl),
        .x_in    (price_ext),
        .busy    (slow_busy),
        .acc     (slow_acc)
    );

    macd_serial_avg #(
        .Period (SignalPeriod)
    ) u_sig_avg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sig_ctrl),
        .x_in    (macd_ext),
        .busy    (sig_busy),
        .acc     (sig_acc)
    );

    macd_serial_sub u_sub (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sub_start),
        .a_in    (sub_a),
        .b_in    (sub_b),
        .busy    (sub_busy),
        .result  (sub_result)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for macd_indicator_stream: sends price series through
// the valid/ready input, predicts each MACD result and checks it field by field.
// Depends on macd_pkg and the block's RTL.
module testbench;
    import macd_pkg::*;

    localparam int unsigned FAST_N      = FAST_PERIOD_DEF;
    localparam int unsigned SLOW_N      = SLOW_PERIOD_DEF;
    localparam int unsigned SIGNAL_N    = SIGNAL_PERIOD_DEF;
    localparam int unsigned WARMUP_LEN  = SLOW_N + SIGNAL_N - 2;
    localparam int unsigned WINDOW_MAX  = (FAST_N > SLOW_N) ? FAST_N : SLOW_N;
    localparam int unsigned COUNT_LIMIT = (WINDOW_MAX > WARMUP_LEN + 1) ?
                                          WINDOW_MAX : WARMUP_LEN + 1;

    localparam int unsigned RANDOM_ITEMS     = 380;
    localparam int unsigned LONG_HOLD_CYCLES = 900;
    // Margin for the tail after the last expected result.
    localparam int unsigned DRAIN_CYCLES     = 400;
    localparam int unsigned STALL_LIMIT      = 6000;
    localparam logic [PRICE_WIDTH-1:0] PRICE_MAX = '1;

    typedef struct packed {
        logic [PRICE_WIDTH-1:0] price;
        logic [PRICE_WIDTH-1:0] fast;
        logic [PRICE_WIDTH-1:0] slow;
        logic [PRICE_WIDTH-1:0] macd;
        logic [PRICE_WIDTH-1:0] signal;
        logic [PRICE_WIDTH-1:0] hist;
    } macd_result_t;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_WALK,
        SHAPE_STEPS,
        SHAPE_FLAT
    } price_shape_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [PRICE_WIDTH-1:0]        s_close_price = '0;
    logic                          s_start_of_series = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [PRICE_WIDTH-1:0]        m_price_echo;
    logic [PRICE_WIDTH-1:0]        m_fast_average;
    logic [PRICE_WIDTH-1:0]        m_slow_average;
    logic signed [PRICE_WIDTH-1:0] m_macd_line;
    logic signed [PRICE_WIDTH-1:0] m_signal_line;
    logic signed [PRICE_WIDTH-1:0] m_histogram;

    // Shadow state of the indicator.
    int unsigned       series_count = 0;
    longint unsigned   fast_acc = 0;
    longint unsigned   slow_acc = 0;
    longint            signal_acc = 0;

    macd_result_t      pending_results[$];
    macd_result_t      result_want;
    int unsigned       fail_count = 0;
    int unsigned       items_sent = 0;
    int unsigned       quiet_cycles = 0;

    // Idle control shared by both sides; the long receiver hold is requested
    // by a test and counted down in the receiver process.
    bit                idle_on = 1'b1;
    bit                sink_hold_req = 1'b0;
    int unsigned       sink_hold_left = 0;
    int unsigned       sink_pause_left = 0;

    macd_indicator_stream dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_close_price     (s_close_price),
        .s_start_of_series (s_start_of_series),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_price_echo      (m_price_echo),
        .m_fast_average    (m_fast_average),
        .m_slow_average    (m_slow_average),
        .m_macd_line       (m_macd_line),
        .m_signal_line     (m_signal_line),
        .m_histogram       (m_histogram)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Window sum until the window closes, then the plain mean, then the
    // exponential recurrence with alpha = 2/(n+1) as an exact rational.
    function automatic longint unsigned average_next(longint unsigned acc, int unsigned idx,
                                                     longint unsigned x, int unsigned n);
        if (idx + 1 < n) return acc + x;
        if (idx + 1 == n) return (acc + x) / n;
        return (2 * x + (n - 1) * acc) / (n + 1);
    endfunction

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advance the shadow state by one price; return 1 when a result is due.
    function automatic bit predict_macd(logic [PRICE_WIDTH-1:0] price, logic restart,
                                        output macd_result_t res);
        int unsigned     idx;
        longint unsigned x;
        longint unsigned fast_seen;
        longint unsigned slow_seen;
        longint          macd;
        longint          sig;
        longint          hist;
        if (restart) begin
            series_count = 0;
            fast_acc = 0;
            slow_acc = 0;
            signal_acc = 0;
        end
        idx = series_count;
        x = price;
        sig = 0;
        res = '0;

        fast_acc = average_next(fast_acc, idx, x, FAST_N);
        slow_acc = average_next(slow_acc, idx, x, SLOW_N);
        // An average that has not closed its window counts as zero.
        fast_seen = (idx + 1 < FAST_N) ? 64'd0 : fast_acc;
        slow_seen = (idx + 1 < SLOW_N) ? 64'd0 : slow_acc;
        macd = clamp_word(longint'(fast_seen) - longint'(slow_seen));

        // The signal average is fed from the first valid slow average on.
        if (idx + 1 >= SLOW_N) begin
            if (idx < WARMUP_LEN) begin
                signal_acc += macd;
            end else if (idx == WARMUP_LEN) begin
                signal_acc = (signal_acc + macd) / longint'(SIGNAL_N);
                sig = signal_acc;
            end else begin
                signal_acc = (2 * macd + longint'(SIGNAL_N - 1) * signal_acc)
                             / longint'(SIGNAL_N + 1);
                sig = signal_acc;
            end
        end

        if (idx < COUNT_LIMIT) series_count = idx + 1;
        if (idx < WARMUP_LEN) return 1'b0;

        hist = clamp_word(macd - sig);
        res.price  = price;
        res.fast   = fast_seen[PRICE_WIDTH-1:0];
        res.slow   = slow_seen[PRICE_WIDTH-1:0];
        res.macd   = macd[PRICE_WIDTH-1:0];
        res.signal = sig[PRICE_WIDTH-1:0];
        res.hist   = hist[PRICE_WIDTH-1:0];
        return 1'b1;
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (!idle_on) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item, hold it until accepted, then record what it must produce.
    task automatic send_price(input logic [PRICE_WIDTH-1:0] price, input logic restart);
        int unsigned  gap;
        macd_result_t res;
        gap = idle_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_close_price     <= price;
        s_start_of_series <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_macd(price, restart, res)) begin
            pending_results.insert(pending_results.size(), res);
        end
        items_sent++;
    endtask

    // Send one series of prices of the given shape; the first item carries
    // the start flag as asked. At index hold_at, request the long receiver hold.
    task automatic send_series(input int unsigned len, input price_shape_t shape,
                               input logic restart, input int hold_at);
        longint                 level;
        longint                 span;
        int unsigned            run_left;
        bit                     at_top;
        logic [PRICE_WIDTH-1:0] price;
        level = $urandom;
        span = longint'(1) << $urandom_range(4, 26);
        run_left = 0;
        at_top = $urandom_range(1);
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_NOISE: begin
                    price = $urandom;
                end
                SHAPE_WALK: begin
                    level = level + longint'($urandom_range(0, 2 * span)) - span;
                    if (level < 0) level = 0;
                    if (level > 64'sh0_FFFF_FFFF) level = 64'sh0_FFFF_FFFF;
                    price = level[PRICE_WIDTH-1:0];
                end
                SHAPE_STEPS: begin
                    // Swing between the extremes to drive MACD and histogram
                    // into saturation.
                    if (run_left == 0) begin
                        at_top = !at_top;
                        run_left = $urandom_range(3, 30);
                    end
                    run_left--;
                    price = at_top ? PRICE_MAX : '0;
                end
                default: begin
                    price = level[PRICE_WIDTH-1:0];
                end
            endcase
            if (i == hold_at) sink_hold_req = 1'b1;
            send_price(price, (i == 0) ? restart : 1'b0);
        end
    endtask

    // Field corners before any start flag, then restarts in the middle of the
    // warm-up and a series of a single sample.
    task automatic test_warmup_and_restart();
        logic [PRICE_WIDTH-1:0] corner_prices[8];
        corner_prices = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
        idle_on = 1'b1;
        foreach (corner_prices[i]) send_price(corner_prices[i], 1'b0);
        send_price(PRICE_MAX, 1'b1);
        send_price(32'h0000_0000, 1'b1);
        send_price(32'h1234_5678, 1'b1);
        for (int i = 0; i < 6; i++) send_price($urandom, 1'b0);
    endtask

    // Full series past the warm-up boundary while the receiver stops for a
    // long stretch, so the result register fills and the input stalls.
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        send_series(WARMUP_LEN + 16, SHAPE_STEPS, 1'b1, WARMUP_LEN + 2);
        idle_on = 1'b1;
    endtask

    // Mostly complete series with random shapes, some broken off during the
    // warm-up, some continuing the previous series without a start flag.
    task automatic test_random_series();
        int unsigned  first_item;
        int unsigned  len;
        price_shape_t shape;
        logic         restart;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            shape = price_shape_t'($urandom_range(0, 3));
            restart = ($urandom_range(0, 9) != 0);
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) len = $urandom_range(1, WARMUP_LEN);
            else len = $urandom_range(WARMUP_LEN + 1, WARMUP_LEN + 50);
            send_series(len, shape, restart, -1);
        end
        idle_on = 1'b1;
    endtask

    // Receiver: random gaps, plus the long hold when a test asks for it.
    always @(posedge aclk) begin
        if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            sink_hold_left = LONG_HOLD_CYCLES;
        end
        if (sink_hold_left != 0) begin
            sink_hold_left--;
            m_ready <= 1'b0;
        end else if (sink_pause_left != 0) begin
            sink_pause_left--;
            m_ready <= 1'b0;
        end else begin
            sink_pause_left = ($urandom_range(0, 7) == 0) ? idle_gap() : 0;
            m_ready <= (sink_pause_left == 0);
        end
    end

    task automatic compare_field(input string field, input logic [PRICE_WIDTH-1:0] want,
                                 input logic [PRICE_WIDTH-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Check every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got price %h",
                         $time, m_price_echo);
                fail_count++;
            end else begin
                result_want = pending_results.pop_front();
                compare_field("price_echo", result_want.price, m_price_echo);
                compare_field("fast_average", result_want.fast, m_fast_average);
                compare_field("slow_average", result_want.slow, m_slow_average);
                compare_field("macd_line", result_want.macd, m_macd_line);
                compare_field("signal_line", result_want.signal, m_signal_line);
                compare_field("histogram", result_want.hist, m_histogram);
            end
        end
    end

    // Count cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_warmup_and_restart();
        test_output_backpressure();
        test_random_series();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
